[src/arcade_shared_bus_decoder_defines.svh]
// assertion macros shared by the bus decoder rtl
`ifndef ARCADE_SHARED_BUS_DECODER_DEFINES_SVH
`define ARCADE_SHARED_BUS_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ASBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/asbd_pkg.sv]
`default_nettype none

package asbd_pkg;

	// ram depths and their index widths
	localparam int VIDEO_DEPTH  = 2048;
	localparam int SHARED_DEPTH = 1024;
	localparam int VIDEO_AW     = $clog2(VIDEO_DEPTH);
	localparam int SHARED_AW    = $clog2(SHARED_DEPTH);

	// offset width wide enough for the largest supported depth
	localparam int OFF_W = 12;

	// memory map
	localparam logic [15:0] ROM_TOP      = 16'h6800;
	localparam logic [15:0] DIP_BASE     = 16'h6800;
	localparam logic [15:0] MISC_BASE    = 16'h6820;
	localparam logic [15:0] MUX_DATA     = 16'h7000;
	localparam logic [15:0] MUX_CTRL     = 16'h7100;
	localparam logic [15:0] VIDEO_BASE   = 16'h8000;
	localparam logic [15:0] SHARED1_BASE = 16'h8800;
	localparam logic [15:0] SHARED2_BASE = 16'h9000;
	localparam logic [15:0] SHARED3_BASE = 16'h9800;
	localparam logic [15:0] VLATCH_BASE  = 16'hA000;
	localparam logic [15:0] VIDEO_SPAN   = 16'h0800;
	localparam logic [15:0] SHARED_SPAN  = 16'h0400;

	// mux control bits
	localparam int CTRL_SEL0 = 0;
	localparam int CTRL_SEL3 = 3;
	localparam int CTRL_READ = 4;

	localparam logic [13:0] NMI_BASE_PERIOD = 14'd64;
	localparam logic [7:0]  STATUS_READY    = 8'h10;

	// configuration port
	localparam int CFG_W  = 24;
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_DIP_A = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_DIP_B = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_BUSY  = 2'd2;
	localparam logic [CFG_W-1:0]  BUSY_RESET = 24'd100000;

	// latch bit positions
	localparam logic [2:0] MISC_IRQ1  = 3'd0;
	localparam logic [2:0] MISC_IRQ2  = 3'd1;
	localparam logic [2:0] MISC_NMI2  = 3'd2;
	localparam logic [2:0] MISC_SUB   = 3'd3;
	localparam logic [2:0] VLATCH_FLIP = 3'd7;
	localparam logic [2:0] STAR_LAST  = 3'd5;
	localparam int FLAG_FLIP = 4;

	// where a read result comes from
	typedef enum logic [2:0] {
		SRC_DIRECT,
		SRC_VIDEO,
		SRC_SHARED_ONE,
		SRC_SHARED_TWO,
		SRC_SHARED_THREE
	} read_src_t;

endpackage

`default_nettype wire

[src/arcade_shared_bus_decoder.sv]
// Shared bus decoder with custom I/O mux.
// Input channel (in_valid/in_ready) carries one bus request: operation,
// address, write_data, the cpu cycle stamp and the byte offered by the
// select-0 input chip. Output channel (out_valid/out_ready) returns one
// result per request: read byte, chip strobes and the latch/timer state
// as left by that request.
// A request's result is registered: it is valid in the cycle after the
// request is accepted; the four RAMs are read through a registered port.
// Throughput is one request per cycle while results are taken; a
// new request is accepted in the same cycle a waiting result is taken.
// When the receiver stalls, the result holds and in_ready drops until
// it is taken; no request is lost.
// Reset clears all latches, the mux control, busy and nmi timers, the
// dip banks and sets busy_cycles to 100000. The RAMs are not cleared:
// reading an entry before writing it returns an unspecified byte.
// Configuration (cfg_we/cfg_index/cfg_data) must be written while idle; the block does not enforce it.
`default_nettype none

`include "arcade_shared_bus_decoder_defines.svh"

module arcade_shared_bus_decoder
	import asbd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              operation,
	input  wire logic [15:0]       address,
	input  wire logic [7:0]        write_data,
	input  wire logic [31:0]       cycle_now,
	input  wire logic [7:0]        chip51_read_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             read_data,
	output logic                   chip51_read_strobe,
	output logic                   chip51_write_strobe,
	output logic                   chip54_write_strobe,
	output logic [7:0]             chip_write_data,
	output logic                   chip51_counter_clear,
	output logic                   chip51_credit_clear,
	output logic [4:0]             latch_flags,
	output logic [5:0]             starfield_bits,
	output logic [13:0]            nmi_period_out,
	output logic [31:0]            nmi_next_cycle,
	output logic [31:0]            release_cycle
);

	// configuration
	logic [7:0]       dip_a_q;
	logic [7:0]       dip_b_q;
	logic [CFG_W-1:0] busy_cycles_q;

	// block state
	logic [7:0]  mux_ctrl_q;
	logic [31:0] busy_until_q;
	logic [13:0] nmi_period_q;
	logic [31:0] nmi_next_q;
	logic [4:0]  flags_q;
	logic [5:0]  star_q;
	logic [31:0] release_q;

	// memories
	logic [7:0] vid_mem [VIDEO_DEPTH];
	logic [7:0] sh1_mem [SHARED_DEPTH];
	logic [7:0] sh2_mem [SHARED_DEPTH];
	logic [7:0] sh3_mem [SHARED_DEPTH];
	logic [7:0] vid_rdata_s1;
	logic [7:0] sh1_rdata_s1;
	logic [7:0] sh2_rdata_s1;
	logic [7:0] sh3_rdata_s1;

	// result stage
	logic       out_valid_q;
	read_src_t  src_s1;
	logic [7:0] rd_s1;
	logic       rs51_s1;
	logic       ws51_s1;
	logic       ws54_s1;
	logic [7:0] cwd_s1;
	logic       cnt_clr_s1;
	logic       cred_clr_s1;

	// decode signals
	logic            accept;
	logic            hit_vid;
	logic            hit_sh1;
	logic            hit_sh2;
	logic            hit_sh3;
	logic [OFF_W-1:0] vid_off;
	logic [OFF_W-1:0] sh_off;
	logic            vid_ok;
	logic            sh_ok;
	logic [2:0]      q_sel;
	logic [31:0]     busy_diff;
	logic [13:0]     new_period;

	// next values
	read_src_t   src_d;
	logic [7:0]  rd_d;
	logic        rs51_d;
	logic        ws51_d;
	logic        ws54_d;
	logic        cnt_clr_d;
	logic        cred_clr_d;
	logic [7:0]  mux_ctrl_d;
	logic [31:0] busy_until_d;
	logic [13:0] nmi_period_d;
	logic [31:0] nmi_next_d;
	logic [4:0]  flags_d;
	logic [5:0]  star_d;
	logic [31:0] release_d;

	// handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// region hits and ram offsets
	assign hit_vid = (address >= VIDEO_BASE) && (address < VIDEO_BASE + VIDEO_SPAN);
	assign hit_sh1 = (address >= SHARED1_BASE) && (address < SHARED1_BASE + SHARED_SPAN);
	assign hit_sh2 = (address >= SHARED2_BASE) && (address < SHARED2_BASE + SHARED_SPAN);
	assign hit_sh3 = (address >= SHARED3_BASE) && (address < SHARED3_BASE + SHARED_SPAN);
	assign vid_off = OFF_W'(address[10:0]);
	assign sh_off  = OFF_W'(address[9:0]);
	assign vid_ok  = 32'(vid_off) < VIDEO_DEPTH;
	assign sh_ok   = 32'(sh_off) < SHARED_DEPTH;
	assign q_sel   = address[2:0];

	// status compare and new nmi period
	assign busy_diff  = cycle_now - busy_until_q;
	assign new_period = NMI_BASE_PERIOD << write_data[7:5];

	// request decode and state update
	always_comb begin
		src_d        = SRC_DIRECT;
		rd_d         = 8'hFF;
		rs51_d       = 1'b0;
		ws51_d       = 1'b0;
		ws54_d       = 1'b0;
		cnt_clr_d    = 1'b0;
		cred_clr_d   = 1'b0;
		mux_ctrl_d   = mux_ctrl_q;
		busy_until_d = busy_until_q;
		nmi_period_d = nmi_period_q;
		nmi_next_d   = nmi_next_q;
		flags_d      = flags_q;
		star_d       = star_q;
		release_d    = release_q;
		if (!operation) begin
			if (address < ROM_TOP) begin
				rd_d = 8'hFF;
			end else if (address < DIP_BASE + 16'd8) begin
				rd_d = {6'b0, dip_a_q[q_sel], dip_b_q[q_sel]};
			end else if (address[15:8] == MUX_DATA[15:8]) begin
				if (mux_ctrl_q[CTRL_READ] && mux_ctrl_q[CTRL_SEL0]) begin
					rd_d   = chip51_read_data;
					rs51_d = 1'b1;
				end
			end else if (address == MUX_CTRL) begin
				rd_d = busy_diff[31] ? 8'h00 : STATUS_READY;
			end else if (hit_vid) begin
				if (vid_ok) src_d = SRC_VIDEO;
			end else if (hit_sh1) begin
				if (sh_ok) src_d = SRC_SHARED_ONE;
			end else if (hit_sh2) begin
				if (sh_ok) src_d = SRC_SHARED_TWO;
			end else if (hit_sh3) begin
				if (sh_ok) src_d = SRC_SHARED_THREE;
			end
		end else begin
			rd_d = 8'h00;
			// voice registers have no read path and are dropped here
			if (address >= MISC_BASE && address < MISC_BASE + 16'd8) begin
				case (q_sel)
					MISC_IRQ1: flags_d[0] = write_data[0];
					MISC_IRQ2: flags_d[1] = write_data[0];
					MISC_NMI2: flags_d[2] = !write_data[0];
					MISC_SUB: begin
						if (write_data[0] && !flags_q[3]) release_d = cycle_now;
						flags_d[3] = write_data[0];
						cred_clr_d = 1'b1;
					end
					default: ;
				endcase
			end else if (address[15:8] == MUX_DATA[15:8]) begin
				if (!mux_ctrl_q[CTRL_READ]) begin
					ws51_d = mux_ctrl_q[CTRL_SEL0];
					ws54_d = mux_ctrl_q[CTRL_SEL3];
				end
			end else if (address == MUX_CTRL) begin
				mux_ctrl_d   = write_data;
				cnt_clr_d    = 1'b1;
				busy_until_d = cycle_now + 32'(busy_cycles_q);
				if (write_data[7:5] == 3'd0) begin
					nmi_period_d = 14'd0;
				end else begin
					nmi_period_d = new_period;
					nmi_next_d   = cycle_now + 32'(new_period);
				end
			end else if (address >= VLATCH_BASE && address < VLATCH_BASE + 16'd8) begin
				if (q_sel <= STAR_LAST) star_d[q_sel] = write_data[0];
				else if (q_sel == VLATCH_FLIP) flags_d[FLAG_FLIP] = write_data[0];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_a_q       <= '0;
			dip_b_q       <= '0;
			busy_cycles_q <= BUSY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIP_A: dip_a_q       <= cfg_data[7:0];
				CFG_DIP_B: dip_b_q       <= cfg_data[7:0];
				CFG_BUSY:  busy_cycles_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latches and timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_ctrl_q   <= '0;
			busy_until_q <= '0;
			nmi_period_q <= '0;
			nmi_next_q   <= '0;
			flags_q      <= '0;
			star_q       <= '0;
			release_q    <= '0;
		end else if (accept) begin
			mux_ctrl_q   <= mux_ctrl_d;
			busy_until_q <= busy_until_d;
			nmi_period_q <= nmi_period_d;
			nmi_next_q   <= nmi_next_d;
			flags_q      <= flags_d;
			star_q       <= star_d;
			release_q    <= release_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1      <= src_d;
			rd_s1       <= rd_d;
			rs51_s1     <= rs51_d;
			ws51_s1     <= ws51_d;
			ws54_s1     <= ws54_d;
			cwd_s1      <= (ws51_d || ws54_d) ? write_data : 8'h00;
			cnt_clr_s1  <= cnt_clr_d;
			cred_clr_s1 <= cred_clr_d;
		end
	end

	// video ram
	always_ff @(posedge clk) begin
		if (accept && hit_vid && vid_ok) begin
			if (operation) vid_mem[vid_off[VIDEO_AW-1:0]] <= write_data;
			else vid_rdata_s1 <= vid_mem[vid_off[VIDEO_AW-1:0]];
		end
	end

	// shared ram one
	always_ff @(posedge clk) begin
		if (accept && hit_sh1 && sh_ok) begin
			if (operation) sh1_mem[sh_off[SHARED_AW-1:0]] <= write_data;
			else sh1_rdata_s1 <= sh1_mem[sh_off[SHARED_AW-1:0]];
		end
	end

	// shared ram two
	always_ff @(posedge clk) begin
		if (accept && hit_sh2 && sh_ok) begin
			if (operation) sh2_mem[sh_off[SHARED_AW-1:0]] <= write_data;
			else sh2_rdata_s1 <= sh2_mem[sh_off[SHARED_AW-1:0]];
		end
	end

	// shared ram three
	always_ff @(posedge clk) begin
		if (accept && hit_sh3 && sh_ok) begin
			if (operation) sh3_mem[sh_off[SHARED_AW-1:0]] <= write_data;
			else sh3_rdata_s1 <= sh3_mem[sh_off[SHARED_AW-1:0]];
		end
	end

	// read data select
	always_comb begin
		case (src_s1)
			SRC_VIDEO:        read_data = vid_rdata_s1;
			SRC_SHARED_ONE:   read_data = sh1_rdata_s1;
			SRC_SHARED_TWO:   read_data = sh2_rdata_s1;
			SRC_SHARED_THREE: read_data = sh3_rdata_s1;
			default:          read_data = rd_s1;
		endcase
	end

	// result outputs
	assign chip51_read_strobe   = rs51_s1;
	assign chip51_write_strobe  = ws51_s1;
	assign chip54_write_strobe  = ws54_s1;
	assign chip_write_data      = cwd_s1;
	assign chip51_counter_clear = cnt_clr_s1;
	assign chip51_credit_clear  = cred_clr_s1;
	assign latch_flags          = flags_q;
	assign starfield_bits       = star_q;
	assign nmi_period_out       = nmi_period_q;
	assign nmi_next_cycle       = nmi_next_q;
	assign release_cycle        = release_q;

	// checks
	`ASBD_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted request gave no result")
	`ASBD_ASSERT_NOW(a_period_power_of_two, 1'b1, $onehot0(nmi_period_out), "nmi period not a power of two")
	`ASBD_ASSERT_NEXT(a_release_holds, !accept, $stable(release_cycle), "release stamp moved without a request")
	`ASBD_ASSERT_NOW(a_strobes_exclusive, out_valid && (chip51_write_strobe || chip54_write_strobe), !chip51_read_strobe && (read_data == 8'h00), "write strobe on a read result")

endmodule

`default_nettype wire

[verif/tb_arcade_shared_bus_decoder.sv]
`timescale 1ns / 1ps

module tb_arcade_shared_bus_decoder;
	import asbd_pkg::*;

	localparam logic OP_READ   = 1'b0;
	localparam logic OP_WRITE  = 1'b1;
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	localparam int IDLE_MAX        = 12;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_REPORT      = 10;
	localparam int PHASES          = 6;
	localparam int PHASE_ITEMS     = 130;
	localparam int STORE_DEPTH     = 4096;
	localparam int DIRECTED_COUNT  = 27;

	typedef struct packed {
		logic        op;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [31:0] cyc;
		logic [7:0]  chip_in;
	} bus_req_t;

	typedef struct packed {
		logic [7:0]  rd;
		logic        rs51;
		logic        ws51;
		logic        ws54;
		logic [7:0]  wdat;
		logic        cnt_clr;
		logic        cred_clr;
		logic [4:0]  flags;
		logic [5:0]  star;
		logic [13:0] period;
		logic [31:0] due;
		logic [31:0] rel_stamp;
	} bus_result_t;

	typedef struct packed {
		bus_req_t   req;
		logic       checked;
		logic [7:0] exp_rd;
	} row_t;

	// directed requests; read bytes typed in where they follow from the map directly
	localparam row_t DIRECTED [DIRECTED_COUNT] = '{
		{OP_READ,  ROM_TOP - 16'd1,  8'h00, 32'd0, 8'h00, TYPED, 8'hFF},
		{OP_READ,  DIP_BASE + 16'd7, 8'hFF, 32'd0, 8'h00, TYPED, 8'h00},
		{OP_READ,  MUX_CTRL, 8'h00, 32'd0, 8'h00, TYPED, STATUS_READY},
		{OP_READ,  MUX_DATA, 8'h00, 32'd0, 8'hFF, TYPED, 8'hFF},
		{OP_WRITE, MUX_DATA + 16'h00FF, 8'h5A, 32'd0, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MUX_CTRL, 8'h19, 32'd1000, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  MUX_CTRL, 8'h00, 32'd1000, 8'h00, TYPED, 8'h00},
		{OP_READ,  MUX_DATA + 16'h0080, 8'h00, 32'd2000, 8'h3C, TYPED, 8'h3C},
		{OP_WRITE, MUX_DATA, 8'hC3, 32'd2000, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MUX_CTRL, 8'hE9, 32'hFFFF_FFF0, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MUX_DATA + 16'h0001, 8'hA5, 32'hFFFF_FFF0, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  MUX_CTRL, 8'h00, 32'hFFFF_FFFF, 8'h00, TYPED, 8'h00},
		{OP_READ,  MUX_CTRL, 8'h00, 32'd99984, 8'h00, TYPED, STATUS_READY},
		{OP_WRITE, MUX_CTRL, 8'h10, 32'd5, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  MUX_DATA, 8'h00, 32'd5, 8'h00, TYPED, 8'hFF},
		{OP_WRITE, MISC_BASE + MISC_NMI2, 8'h00, 32'd6, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MISC_BASE + MISC_SUB, 8'h01, 32'd777, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MISC_BASE + MISC_SUB, 8'hFF, 32'd888, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, MISC_BASE + 16'd7, 8'h01, 32'd900, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, VLATCH_BASE + STAR_LAST, 8'h01, 32'd901, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, VLATCH_BASE + VLATCH_FLIP, 8'hFF, 32'd902, 8'h00, PREDICTED, 8'h00},
		{OP_WRITE, VIDEO_BASE + VIDEO_SPAN - 16'd1, 8'hFF, 32'd903, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  VIDEO_BASE + VIDEO_SPAN - 16'd1, 8'h00, 32'd904, 8'h00, TYPED, 8'hFF},
		{OP_WRITE, SHARED3_BASE, 8'h00, 32'd905, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  SHARED3_BASE, 8'h00, 32'd906, 8'h00, TYPED, 8'h00},
		{OP_WRITE, DIP_BASE + 16'h001F, 8'hFF, 32'd907, 8'h00, PREDICTED, 8'h00},
		{OP_READ,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, TYPED, 8'hFF}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = 1'b0;
	logic [15:0]         address = '0;
	logic [7:0]          write_data = '0;
	logic [31:0]         cycle_now = '0;
	logic [7:0]          chip51_read_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          read_data;
	logic                chip51_read_strobe;
	logic                chip51_write_strobe;
	logic                chip54_write_strobe;
	logic [7:0]          chip_write_data;
	logic                chip51_counter_clear;
	logic                chip51_credit_clear;
	logic [4:0]          latch_flags;
	logic [5:0]          starfield_bits;
	logic [13:0]         nmi_period_out;
	logic [31:0]         nmi_next_cycle;
	logic [31:0]         release_cycle;

	arcade_shared_bus_decoder dut (.*);

	always #2 clk = ~clk;

	// decoder model state
	logic [7:0]  ram_img [4][STORE_DEPTH];
	bit          ram_valid [4][STORE_DEPTH];
	logic [15:0] written_addrs [$];
	bus_result_t bus_results_due [$];
	logic [7:0]  model_ctrl;
	logic [31:0] busy_stamp;
	logic [13:0] timer_period;
	logic [31:0] timer_due;
	logic [4:0]  latch_bits;
	logic [5:0]  star_bits;
	logic [31:0] sub_release_at;
	logic [7:0]  dip_a_cfg;
	logic [7:0]  dip_b_cfg;
	logic [23:0] busy_len_cfg;

	// stimulus state and statistics
	logic [31:0] cpu_clock = '0;
	int unsigned clock_stride = 2;
	bit          send_idle = 1'b1;
	int          fail_count = 0;
	int          results_seen = 0;
	int          cycle_count = 0;
	int          n_reads = 0;
	int          n_writes = 0;
	int          n_busy = 0;
	int          n_ready = 0;
	int          n_chip_reads = 0;
	int          n_ram_reads = 0;
	bus_result_t seen_result;
	bus_result_t due_result;

	function automatic int unsigned bank_depth(input int unsigned bank);
		return (bank == 0) ? VIDEO_DEPTH : SHARED_DEPTH;
	endfunction

	function automatic logic [15:0] bank_base(input int unsigned bank);
		case (bank)
			0: return VIDEO_BASE;
			1: return SHARED1_BASE;
			2: return SHARED2_BASE;
			default: return SHARED3_BASE;
		endcase
	endfunction

	// which ram an address falls in, and the offset inside it
	function automatic bit ram_locate(input logic [15:0] a, output int unsigned bank,
			output int unsigned off);
		bank = 0;
		off = 0;
		if (a >= VIDEO_BASE && a < VIDEO_BASE + VIDEO_SPAN) begin
			bank = 0;
			off = 32'(a - VIDEO_BASE);
			return 1'b1;
		end
		for (int b = 1; b < 4; b++) begin
			if (a >= bank_base(b) && a < bank_base(b) + SHARED_SPAN) begin
				bank = b;
				off = 32'(a - bank_base(b));
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic string result_text(input bus_result_t r);
		return $sformatf("rd=%h rs51=%b ws51=%b ws54=%b wd=%h cclr=%b crclr=%b flags=%b %s",
			r.rd, r.rs51, r.ws51, r.ws54, r.wdat, r.cnt_clr, r.cred_clr, r.flags,
			$sformatf("star=%b per=%0d nmi=%h rel=%h", r.star, r.period, r.due, r.rel_stamp));
	endfunction

	task automatic reset_model();
		for (int b = 0; b < 4; b++)
			for (int i = 0; i < STORE_DEPTH; i++)
				ram_valid[b][i] = 1'b0;
		written_addrs.delete();
		model_ctrl = '0;
		busy_stamp = '0;
		timer_period = '0;
		timer_due = '0;
		latch_bits = '0;
		star_bits = '0;
		sub_release_at = '0;
		dip_a_cfg = '0;
		dip_b_cfg = '0;
		busy_len_cfg = BUSY_RESET;
	endtask

	// one bus request through the decoder model, result as the block should give it
	task automatic decode_access(input bus_req_t r, output bus_result_t e);
		int unsigned bank;
		int unsigned off;
		logic [31:0] lag;
		logic [2:0]  q;
		logic        hit;
		e = '0;
		q = r.addr[2:0];
		hit = ram_locate(r.addr, bank, off);
		if (r.op == OP_READ) begin
			e.rd = 8'hFF;
			if (r.addr >= DIP_BASE && r.addr < DIP_BASE + 16'd8) begin
				e.rd = {6'b0, dip_a_cfg[q], dip_b_cfg[q]};
			end else if (r.addr >= MUX_DATA && r.addr < MUX_CTRL) begin
				// only the select-0 chip answers, and only in read mode
				if (model_ctrl[CTRL_READ] && model_ctrl[CTRL_SEL0]) begin
					e.rd = r.chip_in;
					e.rs51 = 1'b1;
				end
			end else if (r.addr == MUX_CTRL) begin
				// busy while the signed distance to the stamp is negative
				lag = r.cyc - busy_stamp;
				e.rd = lag[31] ? 8'h00 : STATUS_READY;
			end else if (hit && off < bank_depth(bank)) begin
				e.rd = ram_img[bank][off];
			end
		end else begin
			if (r.addr >= MISC_BASE && r.addr < MISC_BASE + 16'd8) begin
				// misc latch bits 0-3 land on the same flag bits
				case (q)
					MISC_IRQ1, MISC_IRQ2: latch_bits[q] = r.wdata[0];
					MISC_NMI2: latch_bits[q] = ~r.wdata[0];
					MISC_SUB: begin
						if (r.wdata[0] && !latch_bits[q])
							sub_release_at = r.cyc;
						latch_bits[q] = r.wdata[0];
						e.cred_clr = 1'b1;
					end
					default: ;
				endcase
			end else if (r.addr >= MUX_DATA && r.addr < MUX_CTRL) begin
				if (!model_ctrl[CTRL_READ]) begin
					e.ws51 = model_ctrl[CTRL_SEL0];
					e.ws54 = model_ctrl[CTRL_SEL3];
				end
			end else if (r.addr == MUX_CTRL) begin
				model_ctrl = r.wdata;
				e.cnt_clr = 1'b1;
				busy_stamp = r.cyc + {8'h00, busy_len_cfg};
				// zero period field stops the timer and keeps the old stamp
				if (r.wdata[7:5] == 3'd0) begin
					timer_period = '0;
				end else begin
					timer_period = NMI_BASE_PERIOD << r.wdata[7:5];
					timer_due = r.cyc + {18'h0, timer_period};
				end
			end else if (hit) begin
				if (off < bank_depth(bank)) begin
					ram_img[bank][off] = r.wdata;
					if (!ram_valid[bank][off]) begin
						ram_valid[bank][off] = 1'b1;
						written_addrs.push_back(r.addr);
					end
				end
			end else if (r.addr >= VLATCH_BASE && r.addr < VLATCH_BASE + 16'd8) begin
				if (q <= STAR_LAST)
					star_bits[q] = r.wdata[0];
				else if (q == VLATCH_FLIP)
					latch_bits[FLAG_FLIP] = r.wdata[0];
			end
			if (e.ws51 || e.ws54)
				e.wdat = r.wdata;
		end
		e.flags = latch_bits;
		e.star = star_bits;
		e.period = timer_period;
		e.due = timer_due;
		e.rel_stamp = sub_release_at;
	endtask

	// random request, mostly aimed at a decoded region
	task automatic make_request(output bus_req_t r);
		int unsigned pick;
		int unsigned bank;
		int unsigned off;
		if ($urandom_range(0, 39) == 0)
			cpu_clock = $urandom();
		else
			cpu_clock += $urandom_range(0, clock_stride);
		r.op = 1'($urandom_range(0, 1));
		r.addr = 16'($urandom());
		r.wdata = 8'($urandom());
		r.cyc = cpu_clock;
		r.chip_in = 8'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// unshaped noise
		end else if (pick < 25 || (pick < 40 && written_addrs.size() == 0)) begin
			bank = $urandom_range(0, 3);
			off = $urandom_range(0, bank_depth(bank) - 1);
			r.op = OP_WRITE;
			r.addr = bank_base(bank) + off[15:0];
		end else if (pick < 40) begin
			r.op = OP_READ;
			r.addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
		end else if (pick < 46) begin
			r.op = OP_READ;
			r.addr = 16'(DIP_BASE + $urandom_range(0, 7));
		end else if (pick < 50) begin
			r.op = OP_WRITE;
			r.addr = 16'(DIP_BASE + $urandom_range(0, 31));
		end else if (pick < 60) begin
			r.op = OP_WRITE;
			r.addr = 16'(MISC_BASE + $urandom_range(0, 7));
		end else if (pick < 65) begin
			r.op = OP_WRITE;
			r.addr = MUX_CTRL;
		end else if (pick < 80) begin
			r.addr = 16'(MUX_DATA + $urandom_range(0, 255));
		end else if (pick < 87) begin
			r.op = OP_READ;
			r.addr = MUX_CTRL;
		end else if (pick < 94) begin
			r.op = OP_WRITE;
			r.addr = 16'(VLATCH_BASE + $urandom_range(0, 7));
		end else begin
			case ($urandom_range(0, 3))
				0: r.addr = 16'($urandom_range(0, ROM_TOP - 1));
				1: r.addr = 16'($urandom_range(MUX_CTRL + 1, VIDEO_BASE - 1));
				2: r.addr = 16'($urandom_range(SHARED1_BASE + SHARED_SPAN, SHARED2_BASE - 1));
				default: r.addr = 16'($urandom_range(VLATCH_BASE + 8, 16'hFFFF));
			endcase
		end
		// never read a ram entry that has not been written
		if (r.op == OP_READ && ram_locate(r.addr, bank, off) && off < bank_depth(bank)
				&& !ram_valid[bank][off])
			r.op = OP_WRITE;
	endtask

	// present one request, wait for the handshake, queue its expected result
	task automatic send_request(input bus_req_t r, input logic checked,
			input logic [7:0] exp_rd);
		int unsigned gap;
		bus_result_t e;
		gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= r.op;
		address <= r.addr;
		write_data <= r.wdata;
		cycle_now <= r.cyc;
		chip51_read_data <= r.chip_in;
		do @(posedge clk); while (!in_ready);
		decode_access(r, e);
		if (checked)
			e.rd = exp_rd;
		bus_results_due.push_back(e);
		if (r.op == OP_WRITE)
			n_writes++;
		else
			n_reads++;
		if (r.op == OP_READ && r.addr == MUX_CTRL) begin
			if (e.rd == STATUS_READY)
				n_ready++;
			else
				n_busy++;
		end
		if (e.rs51)
			n_chip_reads++;
		if (r.op == OP_READ && r.addr >= VIDEO_BASE && r.addr < VLATCH_BASE && e.rd !== 8'hFF)
			n_ram_reads++;
	endtask

	task automatic release_bus();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (bus_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IW-1:0] index, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_DIP_A: dip_a_cfg = value[7:0];
			CFG_DIP_B: dip_b_cfg = value[7:0];
			CFG_BUSY:  busy_len_cfg = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] dip_a, input logic [7:0] dip_b,
			input logic [23:0] busy_len);
		set_register(CFG_DIP_A, {16'h0, dip_a});
		set_register(CFG_DIP_B, {16'h0, dip_b});
		set_register(CFG_BUSY, busy_len);
	endtask

	// result taker with random stalls, stretches of back-to-back takes
	initial begin
		int unsigned stall;
		int          taken;
		bit          recv_idle;
		taken = 0;
		recv_idle = 1'b1;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0)
				recv_idle = ($urandom_range(0, 2) != 0);
			stall = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result.rd = read_data;
			seen_result.rs51 = chip51_read_strobe;
			seen_result.ws51 = chip51_write_strobe;
			seen_result.ws54 = chip54_write_strobe;
			seen_result.wdat = chip_write_data;
			seen_result.cnt_clr = chip51_counter_clear;
			seen_result.cred_clr = chip51_credit_clear;
			seen_result.flags = latch_flags;
			seen_result.star = starfield_bits;
			seen_result.period = nmi_period_out;
			seen_result.due = nmi_next_cycle;
			seen_result.rel_stamp = release_cycle;
			results_seen++;
			if (bus_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORT)
					$display("unexpected result %0d: %s", results_seen,
						result_text(seen_result));
			end else begin
				due_result = bus_results_due.pop_front();
				if (seen_result !== due_result) begin
					fail_count++;
					if (fail_count <= MAX_REPORT) begin
						$display("mismatch on result %0d", results_seen);
						$display("  exp %s", result_text(due_result));
						$display("  got %s", result_text(seen_result));
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		bus_req_t    req;
		int unsigned phase;
		int unsigned n;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		reset_model();

		// directed requests under reset settings
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_request(DIRECTED[i].req, DIRECTED[i].checked, DIRECTED[i].exp_rd);
		release_bus();
		wait_drained();

		// random phases, each under its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(8'hFF, 8'h00, 24'd1);
				1: configure(8'h00, 8'hFF, 24'hFF_FFFF);
				2: configure(8'($urandom), 8'($urandom), BUSY_RESET);
				3: configure(8'($urandom), 8'($urandom), 24'($urandom_range(1, 5000)));
				4: configure(8'hA5, 8'h5A, 24'($urandom_range(1, 24'hFF_FFFF)));
				default: configure(8'hFF, 8'hFF, 24'd64);
			endcase
			clock_stride = busy_len_cfg / 6 + 2;
			// one phase runs the cycle counter across its wrap
			if (phase == 2)
				cpu_clock = 32'hFFFF_0000;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					send_idle = ($urandom_range(0, 2) != 0);
				make_request(req);
				send_request(req, PREDICTED, 8'h00);
				if ($urandom_range(0, 99) == 0) begin
					release_bus();
					wait_drained();
				end
			end
			release_bus();
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("checked %0d requests (%0d reads, %0d writes) over %0d register settings",
			results_seen, n_reads, n_writes, PHASES + 1);
		$display("mux status busy %0d / ready %0d, %0d chip reads, %0d ram read-backs",
			n_busy, n_ready, n_chip_reads, n_ram_reads);
		if (fail_count == 0 && bus_results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/asbd_pkg.sv
src/arcade_shared_bus_decoder.sv
verif/tb_arcade_shared_bus_decoder.sv
